@@ rtl/core/btr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btr_pkg: shared types and constants for the bit matrix transpose store
// Widths of the item fields, store geometry, opcodes and the structs that
// pass between the sequencer, the store and the top level.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int unsigned DataW      = 64;                  // word width
  localparam int unsigned BitW       = $clog2(DataW);       // bit index in a word
  localparam int unsigned RowW       = 8;                   // row index width
  localparam int unsigned WordW      = 2;                   // word index width
  localparam int unsigned AddrW      = RowW + WordW;        // store address width
  localparam int unsigned StoreDepth = 1 << AddrW;          // 1024 words

  localparam logic [BitW-1:0] BitLast = BitW'(DataW - 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // store access for one cycle: one write port and one read port
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // finished transposed word offered by the sequencer
  typedef struct packed {
    logic             vld;
    logic [DataW-1:0] word;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/bit_matrix_transpose_256x256.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Writes: a write beat is stored at its accept edge; one write per cycle
//   while no read is in flight.
// Reads: a read beat blocks new beats through the 64 store reads (one source
//   row per cycle), the state for the last read data and the hand-off to the
//   output register, after which the result shows on out_valid_o.
// Reset: rst_ni (async, active low) clears the sequencer and output valid;
//   the store itself is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// bit_matrix_transpose_256x256: 256x256 bit matrix transpose store
// Write beats store one 64-bit word of a row; read beats return one 64-bit
// word of a row of the transposed matrix.
// ----------------------------------------------------------------------------
module bit_matrix_transpose_256x256 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input beat channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       opcode_i,
  input  wire logic [btr_pkg::RowW-1:0]   row_index_i,
  input  wire logic [btr_pkg::WordW-1:0]  word_index_i,
  input  wire logic [btr_pkg::DataW-1:0]  data_word_i,
  // result beat channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [btr_pkg::DataW-1:0]       result_word_o
);

  btr_pkg::mem_req_t           mem_req;
  logic [btr_pkg::DataW-1:0]   rd_data;
  btr_pkg::result_t            res;
  logic                        res_ready;

  logic                        out_valid_q, out_valid_d;
  logic [btr_pkg::DataW-1:0]   result_word_q, result_word_d;

  // Sequencer: takes beats only when no read is in flight. A write is
  // committed to the store at its accept edge; a read becomes 64 store
  // reads, one per source row, with the column bit gathered on return.
  btr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .row_index_i  (row_index_i),
    .word_index_i (word_index_i),
    .data_word_i  (data_word_i),
    .mem_req_o    (mem_req),
    .rd_data_i    (rd_data),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Row-major word store, registered read.
  btr_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: the finished word moves here as soon as the slot is
  // free or being emptied, so the sequencer returns to idle and can take
  // new beats while the result waits downstream.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    result_word_d = result_word_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.vld && res_ready) begin
      out_valid_d   = 1'b1;
      result_word_d = res.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    result_word_q <= result_word_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_word_o = result_word_q;

endmodule
`default_nettype wire

@@ rtl/core/btr_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btr_store: matrix word store
// 1024 x 64 single-clock memory, one write and one read port, read data
// registered. Contents undefined until written.
// ----------------------------------------------------------------------------
module btr_store (
  input  wire logic                    clk_i,
  input  wire btr_pkg::mem_req_t       req_i,
  output logic [btr_pkg::DataW-1:0]    rd_data_o
);

  logic [btr_pkg::DataW-1:0] mem_q [btr_pkg::StoreDepth];
  logic [btr_pkg::DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

@@ rtl/core/btr_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btr_seq: access sequencer and column gatherer
// Writes go straight to the store. A read walks the 64 source rows of the
// requested transposed word, one store read per cycle, and shifts the
// selected column bit of each returned word into an accumulator.
// ----------------------------------------------------------------------------
module btr_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       opcode_i,
  input  wire logic [btr_pkg::RowW-1:0]   row_index_i,
  input  wire logic [btr_pkg::WordW-1:0]  word_index_i,
  input  wire logic [btr_pkg::DataW-1:0]  data_word_i,
  output btr_pkg::mem_req_t               mem_req_o,
  input  wire logic [btr_pkg::DataW-1:0]  rd_data_i,
  output btr_pkg::result_t                res_o,
  input  wire logic                       res_ready_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_LAST,
    S_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [btr_pkg::BitW-1:0]     cnt_q, cnt_d;
  logic [btr_pkg::RowW-1:0]     row_q, row_d;
  logic [btr_pkg::WordW-1:0]    word_q, word_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [btr_pkg::DataW-1:0]    acc_q, acc_d;
  logic                         accept;
  logic [btr_pkg::BitW-1:0]     bit_sel;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // column c sits at bit 63-(c&63)
  assign bit_sel = btr_pkg::BitLast - row_q[btr_pkg::BitW-1:0];

  always_comb begin
    mem_req_o.we    = accept && (opcode_i == btr_pkg::OP_WRITE);
    mem_req_o.waddr = {row_index_i, word_index_i};
    mem_req_o.wdata = data_word_i;
    mem_req_o.re    = (state_q == S_RUN);
    // source row 64*w + k, source word r>>6
    mem_req_o.raddr = {word_q, cnt_q, row_q[btr_pkg::RowW-1:btr_pkg::BitW]};
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    row_d    = row_q;
    word_d   = word_q;
    rd_vld_d = mem_req_o.re;
    acc_d    = acc_q;
    // first source row lands in the MSB after 64 shifts
    if (rd_vld_q) begin
      acc_d = {acc_q[btr_pkg::DataW-2:0], rd_data_i[bit_sel]};
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == btr_pkg::OP_READ)) begin
          state_d = S_RUN;
          cnt_d   = '0;
          row_d   = row_index_i;
          word_d  = word_index_i;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == btr_pkg::BitLast) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      row_q    <= '0;
      word_q   <= '0;
      rd_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      row_q    <= row_d;
      word_q   <= word_d;
      rd_vld_q <= rd_vld_d;
      acc_q    <= acc_d;
    end
  end

  assign res_o.vld  = (state_q == S_DONE);
  assign res_o.word = acc_q;

endmodule
`default_nettype wire

@@ rtl/core/btr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btr_checker: port-level checks for the transpose store
// Watches the top level ports only; attached by bind.
// ----------------------------------------------------------------------------
module btr_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_o,
  input  wire logic                       opcode_i,
  input  wire logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  input  wire logic [btr_pkg::DataW-1:0]  result_word_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_word_o))
    else $error("result beat dropped or changed while stalled");

  // an accepted read takes input ready low, blocking further beats
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == btr_pkg::OP_READ) |=> !in_ready_o)
    else $error("input ready while a read is in flight");

  // a read result never appears right after accept
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == btr_pkg::OP_READ) |=> !$rose(out_valid_o))
    else $error("read result too early");

  // a new result only comes out of a busy period
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without a read in flight");

endmodule

bind bit_matrix_transpose_256x256 btr_checker u_btr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .opcode_i      (opcode_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_word_o (result_word_o)
);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bit_matrix_transpose_256x256
// Writes stored row words, reads transposed row words and checks each read
// against a shadow copy of the store. Reads only touch 64-row blocks that
// were written in full. Traffic runs under four sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 100;   // settling margin after the last owed word

  typedef enum int {
    FILL_RANDOM,
    FILL_IDENTITY,
    FILL_ONES
  } fill_kind_e;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic                          opcode_i      = btr_pkg::OP_WRITE;
  logic [btr_pkg::RowW-1:0]      row_index_i   = '0;
  logic [btr_pkg::WordW-1:0]     word_index_i  = '0;
  logic [btr_pkg::DataW-1:0]     data_word_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [btr_pkg::DataW-1:0]     result_word_o;

  // shadow of the stored matrix, addressed {row, word} like the block
  logic [btr_pkg::DataW-1:0]  shadow_store [btr_pkg::StoreDepth];
  // transposed words still owed by the block, oldest first
  logic [btr_pkg::DataW-1:0]  pending_words [$];
  logic [btr_pkg::DataW-1:0]  owed_word;

  int unsigned       error_count   = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  bit_matrix_transpose_256x256 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .row_index_i   (row_index_i),
    .word_index_i  (word_index_i),
    .data_word_i   (data_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_word_o (result_word_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bit b of transposed word (trow, tword) is stored row 64*tword+63-b,
  // word trow>>6, at bit 63-(trow&63).
  function automatic logic [btr_pkg::DataW-1:0] transpose_word(
      logic [btr_pkg::RowW-1:0] trow, logic [btr_pkg::WordW-1:0] tword);
    logic [btr_pkg::DataW-1:0] acc;
    logic [btr_pkg::RowW-1:0]  src_row;
    acc = '0;
    for (int b = 0; b < btr_pkg::DataW; b++) begin
      src_row = {tword, 6'd63 - 6'(b)};
      acc[b]  = shadow_store[{src_row, trow[7:6]}][6'd63 - trow[5:0]];
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, logic [btr_pkg::DataW-1:0] got,
                                 logic [btr_pkg::DataW-1:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one beat and hold it until accepted. Valid is only dropped for an
  // idle gap, so a back-to-back beat never sees valid fall and rise in one step.
  task automatic send_beat(btr_pkg::opcode_e op, logic [btr_pkg::RowW-1:0] row,
                           logic [btr_pkg::WordW-1:0] word,
                           logic [btr_pkg::DataW-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    row_index_i  <= row;
    word_index_i <= word;
    data_word_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: update the shadow or queue the owed word
    if (op == btr_pkg::OP_WRITE) begin
      shadow_store[{row, word}] = data;
    end else begin
      pending_words.push_back(transpose_word(row, word));
    end
  endtask

  // Write word src_word of the 64 rows of block blk.
  task automatic write_row_block(int unsigned src_word, int unsigned blk,
                                 fill_kind_e kind);
    logic [btr_pkg::DataW-1:0] data;
    for (int i = 0; i < 64; i++) begin
      case (kind)
        FILL_IDENTITY: data = 64'h1 << (63 - i);
        FILL_ONES:     data = '1;
        default:       data = {$urandom, $urandom};
      endcase
      send_beat(btr_pkg::OP_WRITE, btr_pkg::RowW'(blk * 64 + i),
                btr_pkg::WordW'(src_word), data);
    end
  endtask

  // Corner cases: identity block reads back as identity, all-ones block,
  // overwrites of the first and last source rows, extremes of both indexes,
  // read beats carrying all-zero and all-one data (ignored).
  task automatic test_corner_reads();
    write_row_block(0, 0, FILL_IDENTITY);
    send_beat(btr_pkg::OP_READ,  8'd0,   2'd0, '1);
    send_beat(btr_pkg::OP_READ,  8'd63,  2'd0, '0);
    send_beat(btr_pkg::OP_READ,  8'd37,  2'd0, {$urandom, $urandom});
    send_beat(btr_pkg::OP_WRITE, 8'd0,   2'd0, '1);
    send_beat(btr_pkg::OP_READ,  8'd0,   2'd0, '0);
    send_beat(btr_pkg::OP_READ,  8'd1,   2'd0, '1);
    write_row_block(3, 3, FILL_ONES);
    send_beat(btr_pkg::OP_READ,  8'd255, 2'd3, '0);
    send_beat(btr_pkg::OP_READ,  8'd192, 2'd3, '1);
    send_beat(btr_pkg::OP_WRITE, 8'd255, 2'd3, '0);
    send_beat(btr_pkg::OP_WRITE, 8'd192, 2'd3, 64'h8000_0000_0000_0001);
    send_beat(btr_pkg::OP_WRITE, 8'd200, 2'd3, 64'haaaa_aaaa_aaaa_aaaa);
    send_beat(btr_pkg::OP_READ,  8'd255, 2'd3, '0);
    send_beat(btr_pkg::OP_READ,  8'd192, 2'd3, '0);
    send_beat(btr_pkg::OP_READ,  8'd200, 2'd3, '1);
    send_beat(btr_pkg::OP_READ,  8'd201, 2'd3, '0);
  endtask

  // Fill word src_word of all 256 rows so that every transposed row in
  // that 64-row band can be read at every word index.
  task automatic test_block_fill(int unsigned src_word);
    for (int blk = 0; blk < 4; blk++) write_row_block(src_word, blk, FILL_RANDOM);
  endtask

  // Random writes anywhere, reads only from bands 0..top_band (all written).
  task automatic test_mixed_traffic(int unsigned n_beats, int unsigned top_band);
    for (int n = 0; n < n_beats; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        send_beat(btr_pkg::OP_WRITE, btr_pkg::RowW'($urandom_range(0, 255)),
                  btr_pkg::WordW'($urandom_range(0, 3)), {$urandom, $urandom});
      end else begin
        send_beat(btr_pkg::OP_READ,
                  btr_pkg::RowW'($urandom_range(0, 64 * (top_band + 1) - 1)),
                  btr_pkg::WordW'($urandom_range(0, 3)), {$urandom, $urandom});
      end
    end
  endtask

  // Result side: check each accepted beat, then redraw ready for next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch("result with nothing owed", result_word_o, '0);
        end else begin
          owed_word = pending_words.pop_front();
          if (result_word_o !== owed_word) begin
            report_mismatch("result_word", result_word_o, owed_word);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long with no beat moving on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_reads();

    // idle mixes: none, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      test_block_fill(p);
      test_mixed_traffic(120, p);
    end

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
